FILE: rtl/dbb_pkg.sv
package dbb_pkg;

    localparam int LEVEL_DEF = 3;
    localparam int ORDER_DEF = 4;

    // queued sample, already classified
    typedef struct packed {
        logic [16:0] x;
        logic        ok;    // sample below 1.0
        logic [4:0]  cidx;  // knot cell holding the sample
    } t_job;

    // engine to emitter handover
    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [4:0] cidx;
    } t_hand;

    // round(2^32/d) in Q0.32, zero for an empty span
    function automatic logic [32:0] recip(input logic [2:0] d);
        logic [32:0] r;
        case (d)
            3'd1:    r = 33'h1_0000_0000;
            3'd2:    r = 33'd2147483648;
            3'd3:    r = 33'd1431655765;
            3'd4:    r = 33'd1073741824;
            3'd5:    r = 33'd858993459;
            3'd6:    r = 33'd715827883;
            3'd7:    r = 33'd613566757;
            default: r = '0;
        endcase
        return r;
    endfunction

    // clamped knot position in whole cells
    function automatic logic [5:0] knot_unit(input logic [7:0] k, input int level,
                                             input int order);
        logic [7:0] u;
        u = '0;
        if (k >= 8'(order - 1)) begin
            u = k - 8'(order - 1);
            if (u > 8'(1 << level)) begin
                u = 8'(1 << level);
            end
        end
        return u[5:0];
    endfunction

    // clamped knot position in Q0.16
    function automatic logic [16:0] knot_q16(input logic [7:0] k, input int level,
                                             input int order);
        return 17'(knot_unit(k, level, order)) << (16 - level);
    endfunction

endpackage

FILE: rtl/dyadic_bspline_basis_eval_core.sv
// Channel  | Dir | Transaction contents
// s_axis   | in  | tdata[16:0] sample (Q0.16, 65536 = 1.0)
// m_axis   | out | tdata: basis value, basis slope; tuser: basis index; tlast: last of run
//
// One sample gives (2^LEVEL + ORDER - 1) result transactions, 11 at the defaults.
// The back end handles one sample at a time, its pace set by the shared multiply
// datapath stepping through the recursion; a sample at or beyond 1.0 skips it.
// Emission runs in parallel with the next sample's recursion, one result a cycle
// unless m_axis_tready holds it back.
// A two-entry queue sits between input and engine; either side may stall freely.
// Reset is synchronous, active low, and clears control state only.
module dyadic_bspline_basis_eval_core #(
    parameter int LEVEL = dbb_pkg::LEVEL_DEF,
    parameter int ORDER = dbb_pkg::ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] sample, [23:17] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [16:0] basis_value, [40:17] basis_slope, rest zero
    output logic [3:0]  m_axis_tuser,   // [3:0] basis_index
    output logic        m_axis_tlast    // last_of_run
);

    localparam int NBASIS = (1 << LEVEL) + ORDER - 1;

    logic           job_valid;
    dbb_pkg::t_job  job;
    logic           pop;
    logic           emit_free;
    dbb_pkg::t_hand hand;
    logic [30:0]    win_w [ORDER];
    logic [39:0]    win_t [ORDER];
    logic [16:0]    value;
    logic [23:0]    slope;

    // front: classify samples and queue them
    dbb_front #(.LEVEL(LEVEL)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_sample    (s_axis_tdata[16:0]),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_pop       (pop)
    );

    // back: Cox-de Boor recursion over a window of ORDER live functions
    dbb_engine #(.LEVEL(LEVEL), .ORDER(ORDER)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .i_emit_free (emit_free),
        .o_hand      (hand),
        .o_w         (win_w),
        .o_t         (win_t)
    );

    // output stage: one transaction per basis function
    dbb_emit #(.LEVEL(LEVEL), .ORDER(ORDER)) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hand    (hand),
        .i_w       (win_w),
        .i_t       (win_t),
        .o_free    (emit_free),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_index   (m_axis_tuser),
        .o_value   (value),
        .o_slope   (slope),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, slope, value};

    // tlast only ever on the final basis function
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 4'(NBASIS - 1)))
        else $error("tlast on wrong basis index");

    // handover never overwrites a run still being emitted
    a_hand_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hand.valid |-> $past(emit_free))
        else $error("handover while emitter busy");

    // engine pops only a queued sample
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> job_valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/dbb_front.sv
module dbb_front #(
    parameter int LEVEL = dbb_pkg::LEVEL_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  logic [16:0]    i_sample,
    output logic           o_job_valid,
    output dbb_pkg::t_job  o_job,
    input  logic           i_pop
);

    dbb_pkg::t_job r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    dbb_pkg::t_job n_job;
    logic [15:0]   cell_full;
    logic          push;

    assign cell_full  = i_sample[15:0] >> (16 - LEVEL);
    always_comb begin
        n_job.x    = i_sample;
        n_job.ok   = ~i_sample[16];
        n_job.cidx = cell_full[4:0];
    end

    assign o_s_ready   = (r_cnt != 2'd2);
    assign push        = i_s_valid && o_s_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= n_job;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/dbb_engine.sv
module dbb_engine #(
    parameter int LEVEL = dbb_pkg::LEVEL_DEF,
    parameter int ORDER = dbb_pkg::ORDER_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  dbb_pkg::t_job  i_job,
    output logic           o_pop,
    input  logic           i_emit_free,
    output dbb_pkg::t_hand o_hand,
    output logic [30:0]    o_w [ORDER],
    output logic [39:0]    o_t [ORDER]
);

    localparam int KW = $clog2(ORDER);
    localparam logic [7:0] SLOPE_K = 8'((ORDER - 1) << LEVEL);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_ACC, S_SLP1, S_SLP2, S_DONE
    } t_state;

    t_state       r_state;
    logic [16:0]  r_x;
    logic         r_ok;
    logic [4:0]   r_cell;
    logic [30:0]  r_w   [ORDER];
    logic [30:0]  r_low [ORDER];
    logic [39:0]  r_t   [ORDER];
    logic [KW-1:0] r_deg;
    logic [KW-1:0] r_k;
    logic         r_side;
    logic [31:0]  r_acc;
    logic [30:0]  r_b;
    logic [63:0]  r_p1;
    logic [63:0]  r_p2;
    logic         r_hand;

    logic [7:0]   ai;
    logic [16:0]  kt;
    logic [16:0]  num;
    logic [2:0]   span;
    logic [2:0]   sspan;
    logic [30:0]  bsel;
    logic [30:0]  ratio;
    logic [31:0]  term;
    logic [30:0]  n_new;
    logic [31:0]  q;
    logic         last_k;
    logic [30:0]  n_w [ORDER];

    always_comb begin
        ai     = 8'(r_cell) + 8'(r_k);
        last_k = (r_k == KW'(ORDER - 1));
        if (!r_side) begin
            kt   = dbb_pkg::knot_q16(ai, LEVEL, ORDER);
            num  = (r_x >= kt) ? r_x - kt : '0;
            span = 3'(dbb_pkg::knot_unit(ai + 8'(r_deg), LEVEL, ORDER)
                      - dbb_pkg::knot_unit(ai, LEVEL, ORDER));
            bsel = r_w[0];
        end else begin
            kt   = dbb_pkg::knot_q16(ai + 8'(r_deg) + 8'd1, LEVEL, ORDER);
            num  = (kt >= r_x) ? kt - r_x : '0;
            span = 3'(dbb_pkg::knot_unit(ai + 8'(r_deg) + 8'd1, LEVEL, ORDER)
                      - dbb_pkg::knot_unit(ai + 8'd1, LEVEL, ORDER));
            bsel = last_k ? '0 : r_w[1];
        end
        sspan = 3'(dbb_pkg::knot_unit(ai + 8'(ORDER - 1), LEVEL, ORDER)
                   - dbb_pkg::knot_unit(ai, LEVEL, ORDER));
        ratio = 31'((r_p1 + 64'd131072) >> 18);
        term  = 32'((r_p2 + (64'd1 << 29)) >> 30);
        n_new = 31'(r_acc + term);
        q     = 32'((r_p1 + (64'd1 << 31)) >> 32);
        for (int m = 0; m < ORDER - 1; m++) begin
            n_w[m] = r_w[m + 1];
        end
        n_w[ORDER-1] = n_new;
    end

    assign o_pop         = (r_state == S_IDLE) && i_job_valid;
    assign o_hand.valid  = r_hand;
    assign o_hand.ok     = r_ok;
    assign o_hand.cidx   = r_cell;
    assign o_w           = r_w;
    assign o_t           = r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hand  <= 1'b0;
        end else begin
            r_hand <= (r_state == S_DONE) && i_emit_free;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_x    <= i_job.x;
                        r_ok   <= i_job.ok;
                        r_cell <= i_job.cidx;
                        for (int m = 0; m < ORDER; m++) begin
                            r_w[m] <= (m == ORDER - 1) ? 31'(1 << 30) : '0;
                            r_t[m] <= '0;
                        end
                        r_deg   <= KW'(1);
                        r_k     <= '0;
                        r_side  <= 1'b0;
                        r_state <= i_job.ok ? S_MUL1 : S_DONE;
                    end
                end
                S_MUL1: begin
                    r_p1    <= 64'(num) * 64'(dbb_pkg::recip(span)) << LEVEL;
                    r_b     <= bsel;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= 64'(ratio) * 64'(r_b);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_side) begin
                        r_acc   <= term;
                        r_side  <= 1'b1;
                        r_state <= S_MUL1;
                    end else begin
                        r_side <= 1'b0;
                        r_w    <= n_w;
                        if (last_k) begin
                            r_k <= '0;
                            if (r_deg == KW'(ORDER - 1)) begin
                                r_state <= S_SLP1;
                            end else begin
                                // degree below the top: keep it for the slope
                                if (r_deg == KW'(ORDER - 2)) begin
                                    r_low <= n_w;
                                end
                                r_deg   <= r_deg + KW'(1);
                                r_state <= S_MUL1;
                            end
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_SLP1: begin
                    r_p1    <= 64'(r_low[0]) * 64'(dbb_pkg::recip(sspan));
                    r_state <= S_SLP2;
                end
                S_SLP2: begin
                    for (int m = 0; m < ORDER - 1; m++) begin
                        r_low[m] <= r_low[m + 1];
                        r_t[m]   <= r_t[m + 1];
                    end
                    r_low[ORDER-1] <= '0;
                    r_t[ORDER-1]   <= 40'(q) * 40'(SLOPE_K);
                    if (last_k) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_SLP1;
                    end
                end
                S_DONE: begin
                    if (i_emit_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/dbb_emit.sv
module dbb_emit #(
    parameter int LEVEL = dbb_pkg::LEVEL_DEF,
    parameter int ORDER = dbb_pkg::ORDER_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dbb_pkg::t_hand i_hand,
    input  logic [30:0]    i_w [ORDER],
    input  logic [39:0]    i_t [ORDER],
    output logic           o_free,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic [3:0]     o_index,
    output logic [16:0]    o_value,
    output logic [23:0]    o_slope,
    output logic           o_last
);

    localparam int NBASIS = (1 << LEVEL) + ORDER - 1;
    localparam int IW     = $clog2(NBASIS);

    logic          r_busy;
    logic          r_ok;
    logic [4:0]    r_cell;
    logic [IW-1:0] r_i;
    logic [30:0]   r_w [ORDER];
    logic [39:0]   r_t [ORDER];
    logic          r_ov;
    logic [3:0]    r_index;
    logic [16:0]   r_value;
    logic [23:0]   r_slope;
    logic          r_last;

    logic          load;
    logic          inwin;
    logic          is_last;
    logic [17:0]   vr;
    logic [16:0]   n_value;
    logic [39:0]   mag;
    logic [26:0]   mr;
    logic          neg;
    logic [23:0]   n_slope;

    always_comb begin
        is_last = (r_i == IW'(NBASIS - 1));
        inwin   = r_ok && (7'(r_i) >= 7'(r_cell)) && (7'(r_i) < 7'(r_cell) + 7'(ORDER));
        vr      = 18'((32'(r_w[0]) + 32'd8192) >> 14);
        n_value = (vr > 18'd65536) ? 17'd65536 : vr[16:0];
        neg     = r_t[1] > r_t[0];
        mag     = neg ? r_t[1] - r_t[0] : r_t[0] - r_t[1];
        mr      = 27'((41'(mag) + 41'd8192) >> 14);
        if (neg) begin
            n_slope = (mr > 27'd8388608) ? 24'h80_0000 : 24'(-mr);
        end else begin
            n_slope = (mr > 27'd8388607) ? 24'h7F_FFFF : mr[23:0];
        end
        if (!inwin) begin
            n_value = '0;
            n_slope = '0;
        end
    end

    assign load      = r_busy && (!r_ov || i_m_ready);
    assign o_free    = !r_busy;
    assign o_m_valid = r_ov;
    assign o_index   = r_index;
    assign o_value   = r_value;
    assign o_slope   = r_slope;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_m_ready && !load) begin
                r_ov <= 1'b0;
            end
            if (i_hand.valid) begin
                r_busy <= 1'b1;
                r_ok   <= i_hand.ok;
                r_cell <= i_hand.cidx;
                r_i    <= '0;
                r_w    <= i_w;
                r_t    <= i_t;
            end else if (load) begin
                r_ov    <= 1'b1;
                r_index <= 4'(r_i);
                r_value <= n_value;
                r_slope <= n_slope;
                r_last  <= is_last;
                r_i     <= r_i + IW'(1);
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                // window slides one basis function per in-window result
                if (inwin) begin
                    for (int m = 0; m < ORDER - 1; m++) begin
                        r_w[m] <= r_w[m + 1];
                        r_t[m] <= r_t[m + 1];
                    end
                    r_w[ORDER-1] <= '0;
                    r_t[ORDER-1] <= '0;
                end
            end
        end
    end

endmodule
